FILE: sv/shsd_pkg.sv
// shared constants, sync pattern tables and result type for the header sync deframer
package shsd_pkg;

	localparam int HEADER_LEN = 12;
	localparam int POS_W = $clog2(HEADER_LEN);
	localparam int LEN_W = 17;

	localparam logic [7:0] SYNC_VALUE [HEADER_LEN] = '{
		8'hb0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h80, 8'hff, 8'h7f
	};
	localparam logic SYNC_CHECKED [HEADER_LEN] = '{
		1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1
	};

	// header positions whose byte pairs load the held fields, and the last header position
	localparam logic [POS_W-1:0] POS_PIXEL_HI = POS_W'(3);
	localparam logic [POS_W-1:0] POS_STAMP_HI = POS_W'(5);
	localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(7);
	localparam logic [POS_W-1:0] POS_LAST     = POS_W'(HEADER_LEN - 1);

	typedef struct packed {
		logic             is_header;
		logic [15:0]      pixel_index;
		logic [15:0]      stamp;
		logic [LEN_W-1:0] payload_bytes;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] byte_index;
		logic             last_of_frame;
		logic             frame_marker;
		logic [15:0]      frame_number;
	} res_t;

endpackage

FILE: sv/shsd_if.sv
// byte input and result output channel interfaces
interface shsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface shsd_out_if;
	logic        valid;
	logic        ready;
	logic        is_header;
	logic [15:0] pixel_index;
	logic [15:0] stamp;
	logic [16:0] payload_bytes;
	logic [7:0]  data_byte;
	logic [16:0] byte_index;
	logic        last_of_frame;
	logic        frame_marker;
	logic [15:0] frame_number;

	modport source (output valid, output is_header, output pixel_index, output stamp,
		output payload_bytes, output data_byte, output byte_index, output last_of_frame,
		output frame_marker, output frame_number, input ready);
	modport sink (input valid, input is_header, input pixel_index, input stamp,
		input payload_bytes, input data_byte, input byte_index, input last_of_frame,
		input frame_marker, input frame_number, output ready);
endinterface

FILE: sv/serial_header_sync_deframer.sv
// header sync deframer: hunts for a 12-byte sync header and emits header and payload results
//
// rx carries one received byte per request. While hunting, bytes give no result; a full
// header gives one header result (pixel, stamp, payload length), then each payload byte
// gives one result with its index. The result that ends a frame carries last_of_frame,
// and frame_marker with frame_number when the pixel equals the running maximum pixel.
// A header with zero length ends the frame by itself.
// Throughput: one byte per cycle while rx.ready is high; all decode is a compare and a
// 17-bit count between the input handshake and the result register.
// res has an output register and a one-entry skid register: a byte is still taken while
// a result waits, and rx.ready drops only once the skid entry is also occupied.
// Reset (arst_n low) clears the hunt position, the held header fields, the running
// maximum, the frame counter and both output entries.
module serial_header_sync_deframer
	import shsd_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	shsd_in_if.sink        rx,
	shsd_out_if.source     res
);

	logic [POS_W-1:0] header_pos_q;
	logic             in_payload_q;
	logic [7:0]       prev_byte_q;
	logic [15:0]      held_pixel_q;
	logic [15:0]      held_stamp_q;
	logic [LEN_W-1:0] held_length_q;
	logic [LEN_W-1:0] bytes_seen_q;
	logic [15:0]      highest_pixel_q;
	logic [15:0]      frame_count_q;

	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	logic             take;
	logic [POS_W-1:0] pos;
	logic [15:0]      pair;
	logic [15:0]      pixel_nx;
	logic [15:0]      stamp_nx;
	logic [LEN_W-1:0] length_nx;
	logic [15:0]      highest_nx;
	logic [LEN_W-1:0] seen_inc;
	logic             mismatch;
	logic             hdr_done;
	logic             frame_end;
	logic             marker;
	logic             produce;
	res_t             res_new;

	assign rx.ready = !skid_valid_q;
	assign take = rx.valid && rx.ready;

	assign pos  = (header_pos_q > POS_LAST) ? '0 : header_pos_q;
	assign pair = {rx.in_byte, prev_byte_q};
	assign seen_inc = bytes_seen_q + LEN_W'(1);

	always_comb begin
		pixel_nx  = held_pixel_q;
		stamp_nx  = held_stamp_q;
		length_nx = held_length_q;
		if (!in_payload_q) begin
			if (pos == POS_PIXEL_HI) begin
				pixel_nx = pair;
			end
			if (pos == POS_STAMP_HI) begin
				stamp_nx = pair;
			end
			if (pos == POS_LEN_HI) begin
				length_nx = {pair, 1'b0};
			end
		end
		highest_nx = highest_pixel_q;
		if (!in_payload_q && pixel_nx > highest_pixel_q) begin
			highest_nx = pixel_nx;
		end
	end

	assign mismatch = SYNC_CHECKED[pos] && (rx.in_byte != SYNC_VALUE[pos]);
	assign hdr_done = !in_payload_q && !mismatch && (pos == POS_LAST);
	assign produce  = in_payload_q || hdr_done;
	assign frame_end = in_payload_q ? (seen_inc >= held_length_q)
		: (hdr_done && held_length_q == '0);
	assign marker = frame_end && (pixel_nx == highest_nx);

	always_comb begin
		res_new.is_header     = !in_payload_q;
		res_new.pixel_index   = pixel_nx;
		res_new.stamp         = stamp_nx;
		res_new.payload_bytes = length_nx;
		res_new.data_byte     = in_payload_q ? rx.in_byte : 8'h00;
		res_new.byte_index    = in_payload_q ? bytes_seen_q : '0;
		res_new.last_of_frame = frame_end;
		res_new.frame_marker  = marker;
		res_new.frame_number  = marker ? frame_count_q : 16'h0000;
	end

	// deframer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_pos_q    <= '0;
			in_payload_q    <= 1'b0;
			prev_byte_q     <= '0;
			held_pixel_q    <= '0;
			held_stamp_q    <= '0;
			held_length_q   <= '0;
			bytes_seen_q    <= '0;
			highest_pixel_q <= '0;
			frame_count_q   <= '0;
		end else if (take) begin
			prev_byte_q     <= rx.in_byte;
			held_pixel_q    <= pixel_nx;
			held_stamp_q    <= stamp_nx;
			held_length_q   <= length_nx;
			highest_pixel_q <= highest_nx;
			if (in_payload_q) begin
				bytes_seen_q <= seen_inc;
			end else begin
				if (mismatch) begin
					header_pos_q <= '0;
				end else if (hdr_done) begin
					header_pos_q <= '0;
					bytes_seen_q <= '0;
					in_payload_q <= 1'b1;
				end else begin
					header_pos_q <= pos + POS_W'(1);
				end
			end
			if (frame_end) begin
				in_payload_q <= 1'b0;
				header_pos_q <= '0;
			end
			if (marker) begin
				frame_count_q <= frame_count_q + 16'd1;
			end
		end
	end

	// output register with one skid entry
	logic out_free;
	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (out_free) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end
			end else if (take && produce) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_q <= skid_q;
			end
		end else if (take && produce) begin
			if (out_free) begin
				out_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.is_header     = out_q.is_header;
	assign res.pixel_index   = out_q.pixel_index;
	assign res.stamp         = out_q.stamp;
	assign res.payload_bytes = out_q.payload_bytes;
	assign res.data_byte     = out_q.data_byte;
	assign res.byte_index    = out_q.byte_index;
	assign res.last_of_frame = out_q.last_of_frame;
	assign res.frame_marker  = out_q.frame_marker;
	assign res.frame_number  = out_q.frame_number;

endmodule
